// ----- sv/pcidx_pkg.sv -----
// Shared types, constants and binomial table for the position index core.
package pcidx_pkg;

    localparam int IDX_WIDTH  = 64;
    localparam int SQUARES    = 32;
    localparam int GROUPS     = 6;
    localparam int RANK_W     = 30;
    localparam int BINOM_W    = 30;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 6;

    localparam logic [31:0] SQ_ROW_FIRST = 32'h0000000f;
    localparam logic [31:0] SQ_ROW_LAST  = 32'hf0000000;
    localparam logic [31:0] SQ_MIDDLE    = 32'h0ffffff0;
    localparam logic [7:0]  BOARD_SQ     = 8'd32;
    localparam logic [7:0]  MIDDLE_SQ    = 8'd24;
    localparam logic [7:0]  ROW_SQ       = 8'd4;

    localparam logic [63:0] INDEX_MASK = (IDX_WIDTH >= 64) ? {64{1'b1}} :
        ((64'd1 << (IDX_WIDTH % 64)) - 64'd1);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_BACK_WHITE = 3'd0,
        CFG_BACK_BLACK = 3'd1,
        CFG_MID_WHITE  = 3'd2,
        CFG_MID_BLACK  = 3'd3,
        CFG_QUEEN_WHITE = 3'd4,
        CFG_QUEEN_BLACK = 3'd5
    } t_cfg_addr;

    typedef struct packed {
        logic [2:0] back_white;
        logic [2:0] back_black;
        logic [4:0] mid_white;
        logic [4:0] mid_black;
        logic [5:0] queen_white;
        logic [5:0] queen_black;
    } t_counts;

    typedef logic [32:0][32:0][BINOM_W-1:0] t_binom_tab;

    // Pascal triangle; entries with k greater than n stay zero.
    function automatic t_binom_tab build_binom();
        t_binom_tab tab;
        tab = '0;
        for (int n = 0; n <= 32; n++) begin
            tab[n][0] = BINOM_W'(1);
            for (int k = 1; k <= 32; k++) begin
                if (n > 0) begin
                    tab[n][k] = tab[n-1][k-1] + tab[n-1][k];
                end
            end
        end
        return tab;
    endfunction

    localparam t_binom_tab BINOM = build_binom();

    // C(n, k), zero when n is negative or k exceeds n.
    function automatic logic [BINOM_W-1:0] binom_get(input logic signed [7:0] n,
                                                      input logic [5:0] k);
        logic [BINOM_W-1:0] res;
        res = '0;
        if (n >= 0 && {2'b00, k} <= n) begin
            res = BINOM[n[5:0]][k];
        end
        return res;
    endfunction

endpackage

// ----- sv/position_to_combinatorial_index_core.sv -----
// Top level: combinatorial ranking of a 32-square position into a material table index.
// An accepted input beat passes the input, group select, gather, partial sum, rank, product and index registers.
// Throughput is one beat per cycle; a single enable freezes all seven stages on back-pressure.
// The bases follow a count write through the registered base multiplier chain.
// Reset is synchronous and active low; it clears the counts and the valid bits only.
module position_to_combinatorial_index_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // white_squares [31:0], black_squares [63:32], crowned_squares [95:64]
    input  logic [95:0]                     s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // position_index [63:0]
    output logic [63:0]                     m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [pcidx_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [pcidx_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import pcidx_pkg::*;

    t_counts r_counts;
    logic [7:1] r_v;
    logic       r_en;

    logic [31:0] r_white, r_black, r_crown;
    logic [GROUPS-1:0][31:0] r_gval, r_gsel;
    logic [GROUPS-1:0][31:0] n_gval, n_gsel;
    logic [GROUPS-1:0][RANK_W-1:0] rank;
    logic [4:0][63:0] base;
    logic [RANK_W-1:0] r_rank5;
    logic [4:0][61:0]  r_plo;
    logic [4:0][31:0]  r_phi;
    logic [4:0][61:0]  n_plo;
    logic [4:0][31:0]  n_phi;
    logic [63:0]       r_index;
    logic [63:0]       n_index;

    assign r_en          = !r_v[7] || m_axis_tready;
    assign s_axis_tready = r_en;
    assign m_axis_tvalid = r_v[7];
    assign m_axis_tdata  = r_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counts <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_BACK_WHITE:  r_counts.back_white  <= i_cfg_wdata[2:0];
                CFG_BACK_BLACK:  r_counts.back_black  <= i_cfg_wdata[2:0];
                CFG_MID_WHITE:   r_counts.mid_white   <= i_cfg_wdata[4:0];
                CFG_MID_BLACK:   r_counts.mid_black   <= i_cfg_wdata[4:0];
                CFG_QUEEN_WHITE: r_counts.queen_white <= i_cfg_wdata;
                CFG_QUEEN_BLACK: r_counts.queen_black <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (r_en) begin
            r_v <= {r_v[6:1], s_axis_tvalid};
        end
    end

    always_comb begin
        logic [31:0] pw, pb, qw, qb, rev;
        pw = r_white & ~r_crown;
        pb = r_black & ~r_crown;
        qw = r_white & r_crown;
        qb = r_black & r_crown;
        for (int i = 0; i < 8; i++) begin
            rev[4*i +: 4] = pw[4*(7-i) +: 4];
        end
        n_gval[0] = pw;  n_gsel[0] = SQ_ROW_FIRST;
        n_gval[1] = pb;  n_gsel[1] = SQ_ROW_LAST;
        n_gval[2] = rev; n_gsel[2] = SQ_MIDDLE;
        n_gval[3] = pb;  n_gsel[3] = ~pw & SQ_MIDDLE;
        n_gval[4] = qw;  n_gsel[4] = ~(pw | pb);
        n_gval[5] = qb;  n_gsel[5] = ~(pw | pb | qw);
    end

    always_ff @(posedge i_clk) begin
        if (r_en) begin
            r_white <= s_axis_tdata[31:0];
            r_black <= s_axis_tdata[63:32];
            r_crown <= s_axis_tdata[95:64];
            r_gval  <= n_gval;
            r_gsel  <= n_gsel;
        end
    end

    for (genvar g = 0; g < GROUPS; g++) begin : g_rank
        pcidx_group_rank u_rank (
            .i_clk   (i_clk),
            .i_en    (r_en),
            .i_value (r_gval[g]),
            .i_sel   (r_gsel[g]),
            .o_rank  (rank[g])
        );
    end

    pcidx_base u_base (
        .i_clk    (i_clk),
        .i_counts (r_counts),
        .o_base   (base)
    );

    // Group five has weight one; base k weighs group four minus k.
    always_comb begin
        logic [61:0] hi_full;
        for (int k = 0; k < 5; k++) begin
            n_plo[k] = {32'b0, rank[4-k]} * {30'b0, base[k][31:0]};
            hi_full  = {32'b0, rank[4-k]} * {30'b0, base[k][63:32]};
            n_phi[k] = hi_full[31:0];
        end
    end

    always_comb begin
        logic [63:0] lo_sum;
        logic [31:0] hi_sum;
        lo_sum = {34'b0, r_rank5};
        hi_sum = '0;
        for (int k = 0; k < 5; k++) begin
            lo_sum = lo_sum + {2'b0, r_plo[k]};
            hi_sum = hi_sum + r_phi[k];
        end
        n_index = (lo_sum + {hi_sum, 32'b0}) & INDEX_MASK;
    end

    always_ff @(posedge i_clk) begin
        if (r_en) begin
            r_rank5 <= rank[5];
            r_plo   <= n_plo;
            r_phi   <= n_phi;
            r_index <= n_index;
        end
    end

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_en |=> r_v == $past(r_v))
        else $error("valid chain moved during a stall");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_v[1])
        else $error("accepted beat missing from first stage");

    a_chain_shifts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_en |=> r_v[7:2] == $past(r_v[6:1]))
        else $error("valid chain did not advance");

endmodule

// ----- sv/pcidx_group_rank.sv -----
// Three-stage gather and combinatorial rank of one piece group.
module pcidx_group_rank (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [31:0]               i_value,
    input  logic [31:0]               i_sel,
    output logic [pcidx_pkg::RANK_W-1:0] o_rank
);
    import pcidx_pkg::*;

    logic [31:0]      r_gath;
    logic [31:0]      n_gath;
    logic [7:0][31:0] r_part;
    logic [7:0][31:0] n_part;
    logic [RANK_W-1:0] r_rank;
    logic [RANK_W-1:0] n_rank;

    // Each selected square lands at the count of selected squares below it.
    always_comb begin
        logic [31:0] below;
        logic [4:0]  slot;
        n_gath = '0;
        for (int pos = 0; pos < SQUARES; pos++) begin
            below = (32'd1 << pos) - 32'd1;
            slot  = 5'($countones(i_sel & below));
            if (i_sel[pos] && i_value[pos]) begin
                n_gath[slot] = 1'b1;
            end
        end
    end

    always_comb begin
        logic [31:0]        below;
        logic [5:0]         sel_k;
        logic [BINOM_W-1:0] term;
        n_part = '0;
        for (int pos = 0; pos < SQUARES; pos++) begin
            below = (32'd1 << pos) - 32'd1;
            sel_k = 6'($countones(r_gath & below)) + 6'd1;
            term  = r_gath[pos] ? BINOM[6'(pos)][sel_k] : '0;
            n_part[pos/4] = n_part[pos/4] + {2'b00, term};
        end
    end

    always_comb begin
        logic [31:0] acc;
        acc = '0;
        for (int p = 0; p < 8; p++) begin
            acc = acc + r_part[p];
        end
        n_rank = acc[RANK_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gath <= n_gath;
            r_part <= n_part;
            r_rank <= n_rank;
        end
    end

    assign o_rank = r_rank;

endmodule

// ----- sv/pcidx_base.sv -----
// Mixed radix bases derived from the material counts, settled through the registered multiplier chain after a write.
module pcidx_base (
    input  logic               i_clk,
    input  pcidx_pkg::t_counts i_counts,
    output logic [4:0][63:0]   o_base
);
    import pcidx_pkg::*;

    logic [BINOM_W-1:0] r_b_q, r_b_qw, r_b_mb, r_b_mw;
    logic [2:0]         r_b_bb;
    logic [BINOM_W-1:0] r_base0_d1, r_base0_d2, r_b_mb_d;
    logic [2:0]         r_b_bb_d1, r_b_bb_d2;
    logic [59:0]        r_base1, r_pmm, r_base1_d;
    logic [61:0]        r_b2_lo;
    logic [31:0]        r_b2_hi;
    logic [63:0]        r_b3_ll;
    logic [31:0]        r_b3_cross;
    logic [63:0]        r_base2, r_base3, r_base4;
    logic [63:0]        r_base0_d3;
    logic [59:0]        r_base1_d2;
    logic signed [7:0]  free_sq;
    logic [BINOM_W-1:0] bb_full;
    logic [61:0]        b2_hi_full;
    logic [63:0]        b3_lh, b3_hl;

    always_comb begin
        free_sq = BOARD_SQ - {5'b0, i_counts.back_white} - {5'b0, i_counts.back_black}
                - {3'b0, i_counts.mid_white} - {3'b0, i_counts.mid_black};
        bb_full = binom_get(ROW_SQ, {3'b0, i_counts.back_black});
        b2_hi_full = {32'b0, r_base1[59:32]} * r_b_mb_d;
        b3_lh = {32'b0, r_base1[31:0]} * {36'b0, r_pmm[59:32]};
        b3_hl = {36'b0, r_base1[59:32]} * {32'b0, r_pmm[31:0]};
    end

    always_ff @(posedge i_clk) begin
        r_b_q  <= binom_get(free_sq - {2'b0, i_counts.queen_white}, i_counts.queen_black);
        r_b_qw <= binom_get(free_sq, i_counts.queen_white);
        r_b_mb <= binom_get(MIDDLE_SQ - {3'b0, i_counts.mid_white}, {1'b0, i_counts.mid_black});
        r_b_mw <= binom_get(MIDDLE_SQ, {1'b0, i_counts.mid_white});
        r_b_bb <= bb_full[2:0];

        r_base0_d1 <= r_b_q;
        r_base1    <= r_b_q * r_b_qw;
        r_pmm      <= r_b_mb * r_b_mw;
        r_b_mb_d   <= r_b_mb;
        r_b_bb_d1  <= r_b_bb;

        r_base0_d2 <= r_base0_d1;
        r_base1_d  <= r_base1;
        r_b2_lo    <= {30'b0, r_base1[31:0]} * {32'b0, r_b_mb_d};
        r_b2_hi    <= b2_hi_full[31:0];
        r_b3_ll    <= {32'b0, r_base1[31:0]} * {32'b0, r_pmm[31:0]};
        r_b3_cross <= b3_lh[31:0] + b3_hl[31:0];
        r_b_bb_d2  <= r_b_bb_d1;

        r_base0_d3 <= {34'b0, r_base0_d2};
        r_base1_d2 <= r_base1_d;
        r_base2    <= {2'b0, r_b2_lo} + {r_b2_hi, 32'b0};
        r_base3    <= r_b3_ll + {r_b3_cross, 32'b0};

        // The back-row base is at most six, so shifts and adds suffice.
        r_base4 <= (r_b_bb_d2[0] ? r_base3 : 64'd0)
                 + (r_b_bb_d2[1] ? {r_base3[62:0], 1'b0} : 64'd0)
                 + (r_b_bb_d2[2] ? {r_base3[61:0], 2'b0} : 64'd0);
    end

    assign o_base[0] = r_base0_d3;
    assign o_base[1] = {4'b0, r_base1_d2};
    assign o_base[2] = r_base2;
    assign o_base[3] = r_base3;
    assign o_base[4] = r_base4;

endmodule

// ----- tb/position_to_combinatorial_index_core_tb.sv -----
// Testbench for the position index core: predicts each index and checks every output beat.
`timescale 1ns / 1ps

module position_to_combinatorial_index_core_tb;
    import pcidx_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // white_squares [31:0], black_squares [63:32], crowned_squares [95:64]
    logic [95:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // position_index [63:0]
    logic [63:0] m_axis_tdata;
    logic        i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    t_counts     counts;
    logic [63:0] pending_index[$];
    int          error_count;
    int          cycle_count;
    bit          idling_on;

    position_to_combinatorial_index_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // C(n, k), zero outside 0 <= k <= n <= 32.
    function automatic logic [63:0] choose(input int n, input int k);
        logic [63:0] acc;
        acc = 64'd1;
        if (k < 0 || n < 0 || k > n || n > 32) begin
            return 64'd0;
        end
        for (int i = 0; i < k; i++) begin
            acc = acc * 64'(n - i) / 64'(i + 1);
        end
        return acc;
    endfunction

    function automatic logic [31:0] rows_flipped(input logic [31:0] v);
        logic [31:0] r;
        for (int row = 0; row < 8; row++) begin
            r[row*4 +: 4] = v[(7-row)*4 +: 4];
        end
        return r;
    endfunction

    function automatic logic [31:0] squeeze(input logic [31:0] v, input logic [31:0] sel);
        logic [31:0] r;
        int          dst;
        r   = '0;
        dst = 0;
        for (int p = 0; p < 32; p++) begin
            if (sel[p]) begin
                r[dst] = v[p];
                dst++;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] comb_rank(input logic [31:0] v);
        logic [63:0] acc;
        int          seen;
        acc  = '0;
        seen = 0;
        for (int p = 0; p < 32; p++) begin
            if (v[p]) begin
                acc += choose(p, seen + 1);
                seen++;
            end
        end
        return acc;
    endfunction

    function automatic logic [63:0] position_index_of(input logic [95:0] d);
        logic [31:0] pw, pb, qw, qb;
        logic [63:0] r0, r1, r2, r3, r4, r5, idx, base;
        int          free_sq;
        pw = d[31:0] & ~d[95:64];
        pb = d[63:32] & ~d[95:64];
        qw = d[31:0] & d[95:64];
        qb = d[63:32] & d[95:64];
        r0 = comb_rank(pw & SQ_ROW_FIRST);
        r1 = comb_rank(squeeze(pb, SQ_ROW_LAST));
        r2 = comb_rank(squeeze(rows_flipped(pw), SQ_MIDDLE));
        r3 = comb_rank(squeeze(pb, ~pw & SQ_MIDDLE));
        r4 = comb_rank(squeeze(qw, ~(pw | pb)));
        r5 = comb_rank(squeeze(qb, ~(pw | pb | qw)));
        free_sq = 32 - int'(counts.back_white) - int'(counts.back_black)
                - int'(counts.mid_white) - int'(counts.mid_black);
        idx  = r5;
        base = choose(free_sq - int'(counts.queen_white), int'(counts.queen_black));
        idx += r4 * base;
        base *= choose(free_sq, int'(counts.queen_white));
        idx += r3 * base;
        base *= choose(24 - int'(counts.mid_white), int'(counts.mid_black));
        idx += r2 * base;
        base *= choose(24, int'(counts.mid_white));
        idx += r1 * base;
        base *= choose(4, int'(counts.back_black));
        idx += r0 * base;
        return idx & INDEX_MASK;
    endfunction

    task automatic wait_idle();
        while (pending_index.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_count(input t_cfg_addr addr, input logic [5:0] value);
        wait_idle();
        // Let the pipeline and base chain settle around the write.
        repeat (10) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (addr)
            CFG_BACK_WHITE:  counts.back_white  = value[2:0];
            CFG_BACK_BLACK:  counts.back_black  = value[2:0];
            CFG_MID_WHITE:   counts.mid_white   = value[4:0];
            CFG_MID_BLACK:   counts.mid_black   = value[4:0];
            CFG_QUEEN_WHITE: counts.queen_white = value;
            CFG_QUEEN_BLACK: counts.queen_black = value;
            default: ;
        endcase
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_material(input int bw, input int bb, input int mw, input int mb,
                                input int qw, input int qb);
        write_count(CFG_BACK_WHITE, 6'(bw));
        write_count(CFG_BACK_BLACK, 6'(bb));
        write_count(CFG_MID_WHITE, 6'(mw));
        write_count(CFG_MID_BLACK, 6'(mb));
        write_count(CFG_QUEEN_WHITE, 6'(qw));
        write_count(CFG_QUEEN_BLACK, 6'(qb));
    endtask

    task automatic send_position(input logic [95:0] d);
        while (idling_on && $urandom_range(99) < 9) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        pending_index.push_back(position_index_of(d));
    endtask

    // A board drawn square by square: empty, white or black, sometimes crowned.
    function automatic logic [95:0] random_board();
        logic [31:0] w, b, c;
        int          fill;
        fill = $urandom_range(90, 5);
        for (int p = 0; p < 32; p++) begin
            w[p] = 1'b0;
            b[p] = 1'b0;
            if ($urandom_range(99) < fill) begin
                if ($urandom_range(1)) w[p] = 1'b1;
                else b[p] = 1'b1;
            end
            c[p] = ($urandom_range(3) == 0);
        end
        return {c, b, w};
    endfunction

    task automatic run_random(input int n);
        logic [95:0] d;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 80) d = random_board();
            else d = {$urandom(), $urandom(), $urandom()};
            send_position(d);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic test_directed();
        set_material(2, 2, 6, 6, 1, 1);
        send_position('0);
        send_position({32'h0, 32'h0, 32'hffffffff});
        send_position({32'h0, 32'hffffffff, 32'h0});
        send_position({32'hffffffff, 32'h0, 32'hffffffff});
        send_position({32'hffffffff, 32'h0, 32'h0});
        // Squares claimed by both colors.
        send_position({32'h0, 32'hffffffff, 32'hffffffff});
        send_position({32'hffffffff, 32'hffffffff, 32'hffffffff});
        send_position({32'h0, 32'hf0000000, 32'h0000000f});
        send_position({32'h0, 32'h0ffffff0, 32'h0ffffff0});
        send_position({32'h80000001, 32'h80000000, 32'h00000001});
        send_position({32'h00000030, 32'h0c000000, 32'h00000c03});
        send_position({32'h0f0f0f0f, 32'hf0f0f0f0, 32'h0f0f0f0f});
        s_axis_tvalid <= 1'b0;
        // Material that cannot fit: bases fall to zero.
        set_material(4, 4, 24, 24, 32, 32);
        send_position({32'h00ff00ff, 32'hffffffff, 32'h0000ffff});
        send_position({32'hffffffff, 32'h0, 32'h0});
        send_position({32'h12345678, 32'h80000000, 32'h00000001});
        s_axis_tvalid <= 1'b0;
        set_material(7, 7, 31, 31, 63, 63);
        send_position({32'h0, 32'h0, 32'hffffffff});
        send_position({32'h0f0f0f0f, 32'hf0f0f0f0, 32'h0f0f0f0f});
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic test_random_material();
        set_material(0, 0, 0, 0, 0, 0);
        run_random(230);
        set_material(1, 2, 5, 4, 2, 1);
        run_random(225);
        set_material(4, 0, 12, 0, 0, 8);
        run_random(225);
        set_material(0, 4, 0, 12, 16, 0);
        run_random(225);
        set_material(3, 3, 10, 9, 3, 4);
        // Hold back the sender once until every index has come out.
        run_random(150);
        wait_idle();
        run_random(150);
    endtask

    task automatic test_full_rate();
        set_material(2, 1, 8, 7, 5, 6);
        idling_on = 1'b0;
        run_random(200);
        wait_idle();
        idling_on = 1'b1;
        run_random(200);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !idling_on || ($urandom_range(99) >= 9);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_index.size() == 0) begin
                $display("%0t: unexpected beat, actual %h", $time, m_axis_tdata);
                error_count++;
            end else if (pending_index[0] !== m_axis_tdata) begin
                $display("%0t: position_index mismatch, expected %h actual %h",
                         $time, pending_index[0], m_axis_tdata);
                error_count++;
                void'(pending_index.pop_front());
            end else begin
                void'(pending_index.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = CFG_BACK_WHITE;
        i_cfg_wdata   = '0;
        counts        = '0;
        error_count   = 0;
        cycle_count   = 0;
        idling_on     = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_material();
        test_full_rate();

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
